/* src/bfa_pkg.sv */
// Shared types and constants of the bitmap first-fit allocator.
package bfa_pkg;

    localparam int IDX_W     = 10;
    localparam int NUM_W     = 11;
    localparam int CFG_W     = 11;
    localparam int CFGI_W    = 2;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = 5;
    localparam int WSEL_W    = IDX_W - BIT_W;
    localparam int IDX_SPAN  = 1 << IDX_W;
    localparam int SCAN_WORDS = IDX_SPAN / WORD_W;

    localparam logic [NUM_W-1:0] LIMIT_RST = NUM_W'(1024);
    localparam logic [NUM_W-1:0] FREE_RST  = NUM_W'(1024);

    localparam logic [CFGI_W-1:0] REG_FIRST = CFGI_W'(0);
    localparam logic [CFGI_W-1:0] REG_LIMIT = CFGI_W'(1);
    localparam logic [CFGI_W-1:0] REG_FREE  = CFGI_W'(2);

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_TEST    = 2'd1,
        OP_MARK    = 2'd2,
        OP_RELEASE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ISSUE,
        S_CHECK,
        S_FIN
    } t_state;

endpackage

/* src/bfa_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/bitmap_first_fit_allocator.sv */
// Bitmap first-fit allocator top level: word memory, scan sequencer and free counter.
//
// The usage bitmap sits in a RAM of 32-bit words. After reset the block clears the
// RAM, one word a cycle, and accepts no transaction meanwhile; configuration writes
// are taken throughout. Test, mark used and release go from acceptance to result
// through the accept, read, modify and deliver steps; an index outside the map skips
// the read. An allocate with an empty scan range skips the read as well. Otherwise
// the allocate reads the first candidate word and, if that word has no room, one
// further word: a per-word full flag lets the scan jump straight from the first word
// to the first non-full word or the last word, so at most two words are read. One
// transaction is worked on at a time; the result register lets the next transaction
// enter while a result waits.
module bitmap_first_fit_allocator
    import bfa_pkg::*;
#(
    parameter int MAP_BITS = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFGI_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_opcode,
    input  logic [IDX_W-1:0]  i_entry_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_status,
    output logic [NUM_W-1:0]  o_allocated_number,
    output logic              o_bit_used,
    output logic [NUM_W-1:0]  o_free_left
);

    localparam int WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int LIM   = (MAP_BITS < IDX_SPAN) ? MAP_BITS : IDX_SPAN;

    function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] p;
        p = '0;
        for (int k = WORD_W - 1; k >= 0; k--) begin
            if (v[k]) begin
                p = BIT_W'(k);
            end
        end
        return p;
    endfunction

    t_state r_state, n_state;

    logic [IDX_W-1:0]      r_first;
    logic [NUM_W-1:0]      r_limit;
    logic [NUM_W-1:0]      r_free;
    logic [SCAN_WORDS-1:0] r_full;
    logic [AW-1:0]         r_clr;
    logic                  r_out_valid;

    t_op                   r_op;
    logic [IDX_W-1:0]      r_idx;
    logic [WSEL_W-1:0]     r_ptr;
    logic [WSEL_W-1:0]     r_word;
    logic                  r_res_status;
    logic [NUM_W-1:0]      r_res_number;
    logic                  r_res_bit;
    logic [WORD_W-1:0]     r_wdata;
    logic                  r_wpend;
    logic                  r_dec;
    logic                  r_status;
    logic [NUM_W-1:0]      r_number;
    logic                  r_bit;
    logic [NUM_W-1:0]      r_free_out;

    logic [NUM_W-1:0]      stop;
    logic                  range_ok;
    logic [IDX_W-1:0]      last_idx;
    logic [WSEL_W-1:0]     fw;
    logic [WSEL_W-1:0]     lw;
    logic [SCAN_WORDS-1:0] cand;
    logic                  cand_any;
    logic [WSEL_W-1:0]     cand_q;
    logic [WORD_W-1:0]     rdata;
    logic [WORD_W-1:0]     lo_mask;
    logic [WORD_W-1:0]     hi_mask;
    logic [WORD_W-1:0]     free_bits;
    logic                  free_any;
    logic [BIT_W-1:0]      free_b;
    logic [WORD_W-1:0]     sel_oh;
    logic                  out_free;
    logic                  in_acc;
    logic                  in_map;
    logic [NUM_W-1:0]      n_free;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [AW-1:0]         ram_raddr;

    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign in_map     = int'(i_entry_index) < MAP_BITS;
    assign out_free   = !r_out_valid || i_out_ready;

    assign stop     = (r_limit < NUM_W'(LIM)) ? r_limit : NUM_W'(LIM);
    assign range_ok = {1'b0, r_first} < stop;
    assign last_idx = IDX_W'(stop - NUM_W'(1));
    assign fw       = r_first[IDX_W-1:BIT_W];
    assign lw       = last_idx[IDX_W-1:BIT_W];

    always_comb begin
        for (int q = 0; q < SCAN_WORDS; q++) begin
            cand[q] = (WSEL_W'(q) >= r_ptr) && (WSEL_W'(q) <= lw) &&
                      ((WSEL_W'(q) == fw) || (WSEL_W'(q) == lw) || !r_full[q]);
        end
    end

    assign cand_any = |cand;
    assign cand_q   = low_bit(cand);

    assign lo_mask   = (r_word == fw) ? ({WORD_W{1'b1}} << r_first[BIT_W-1:0])
                                      : {WORD_W{1'b1}};
    assign hi_mask   = (r_word == lw)
                     ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - last_idx[BIT_W-1:0]))
                     : {WORD_W{1'b1}};
    assign free_bits = ~rdata & lo_mask & hi_mask;
    assign free_any  = |free_bits;
    assign free_b    = low_bit(free_bits);
    assign sel_oh    = WORD_W'(1) << r_idx[BIT_W-1:0];

    assign n_free = (r_dec && (r_free != '0)) ? r_free - NUM_W'(1) : r_free;

    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_FIN) && out_free && r_wpend);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : AW'(r_word);
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : r_wdata;

    always_comb begin
        n_state   = r_state;
        ram_raddr = AW'(r_idx[IDX_W-1:BIT_W]);
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == AW'(WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if ((t_op'(i_opcode) != OP_ALLOC) && !in_map) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                if (r_op == OP_ALLOC) begin
                    ram_raddr = AW'(cand_q);
                    n_state   = (range_ok && cand_any) ? S_CHECK : S_FIN;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((r_op == OP_ALLOC) && !free_any && (r_word != lw)) begin
                    n_state = S_ISSUE;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_full      <= '0;
            r_first     <= '0;
            r_limit     <= LIMIT_RST;
            r_free      <= FREE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
                r_free      <= n_free;
                if (r_wpend) begin
                    r_full[r_word] <= &r_wdata;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_FIRST: r_first <= i_cfg_data[IDX_W-1:0];
                    REG_LIMIT: r_limit <= i_cfg_data;
                    REG_FREE:  r_free  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op         <= t_op'(i_opcode);
            r_idx        <= i_entry_index;
            r_ptr        <= fw;
            r_res_status <= 1'b0;
            r_res_number <= '0;
            r_res_bit    <= 1'b0;
            r_wpend      <= 1'b0;
            r_dec        <= 1'b0;
        end
        if (r_state == S_ISSUE) begin
            if (r_op == OP_ALLOC) begin
                r_word <= cand_q;
                if (!(range_ok && cand_any)) begin
                    r_res_status <= 1'b1;
                end
            end else begin
                r_word <= r_idx[IDX_W-1:BIT_W];
            end
        end
        if (r_state == S_CHECK) begin
            case (r_op)
                OP_ALLOC: begin
                    if (free_any) begin
                        r_res_number <= {1'b0, r_word, free_b} + NUM_W'(1);
                        r_wdata      <= rdata | (WORD_W'(1) << free_b);
                        r_wpend      <= 1'b1;
                        r_dec        <= 1'b1;
                    end else if (r_word == lw) begin
                        r_res_status <= 1'b1;
                    end else begin
                        r_ptr <= r_word + WSEL_W'(1);
                    end
                end
                OP_TEST: begin
                    r_res_bit <= rdata[r_idx[BIT_W-1:0]];
                end
                OP_MARK: begin
                    r_wdata <= rdata | sel_oh;
                    r_wpend <= 1'b1;
                end
                default: begin
                    r_wdata <= rdata & ~sel_oh;
                    r_wpend <= 1'b1;
                end
            endcase
        end
        if ((r_state == S_FIN) && out_free) begin
            r_status   <= r_res_status;
            r_number   <= r_res_number;
            r_bit      <= r_res_bit;
            r_free_out <= n_free;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_allocated_number = r_number;
    assign o_bit_used         = r_bit;
    assign o_free_left        = r_free_out;

endmodule

/* src/bfa_checker.sv */
// Port-level assertions for the bitmap first-fit allocator, bound to the top level.
module bfa_checker
    import bfa_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_status,
    input logic [NUM_W-1:0] o_allocated_number,
    input logic             o_bit_used,
    input logic [NUM_W-1:0] o_free_left
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
        $stable(o_allocated_number) && $stable(o_bit_used) && $stable(o_free_left))
        else $error("result changed while stalled");

    a_nospace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status |-> (o_allocated_number == '0) && !o_bit_used)
        else $error("no-space result carries a number or bit");

    a_test_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bit_used |-> (o_allocated_number == '0) && !o_status)
        else $error("test result mixed with allocate fields");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction taken while one is in progress");

endmodule

bind bitmap_first_fit_allocator bfa_checker u_bfa_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_status           (o_status),
    .o_allocated_number (o_allocated_number),
    .o_bit_used         (o_bit_used),
    .o_free_left        (o_free_left)
);

/* verif/bitmap_first_fit_allocator_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the bitmap first-fit allocator: directed table, then random phases.
module bitmap_first_fit_allocator_tb;
    import bfa_pkg::*;

    localparam int MAP_BITS        = 1024;
    localparam int DRAIN_CYCLES    = 12;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int DIR_ROWS        = 34;

    localparam logic [CFGI_W-1:0] REG_NONE = CFGI_W'(3);

    typedef struct packed {
        logic             status;
        logic [NUM_W-1:0] number;
        logic             bit_used;
        logic [NUM_W-1:0] free_left;
    } t_outcome;

    typedef struct packed {
        logic              is_reg;
        logic [CFGI_W-1:0] reg_index;
        logic [CFG_W-1:0]  reg_data;
        t_op               op;
        logic [IDX_W-1:0]  idx;
        logic              typed;
        t_outcome          outcome;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFGI_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]  i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    t_op               i_opcode = OP_ALLOC;
    logic [IDX_W-1:0]  i_entry_index = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic              o_status;
    logic [NUM_W-1:0]  o_allocated_number;
    logic              o_bit_used;
    logic [NUM_W-1:0]  o_free_left;

    bit                map_used [MAP_BITS];
    logic [NUM_W-1:0]  free_count = FREE_RST;
    logic [IDX_W-1:0]  scan_first = '0;
    logic [NUM_W-1:0]  scan_limit = LIMIT_RST;

    t_outcome          pending_results [$];
    t_outcome          typed_outcome = '0;
    logic              typed_pending = 1'b0;
    t_outcome          want;
    t_outcome          seen;
    t_stim_row         dir_rows [DIR_ROWS];

    int unsigned       send_idle_pct = 0;
    int unsigned       recv_stall_pct = 0;
    int unsigned       in_count = 0;
    int unsigned       stall_cycles = 0;
    int unsigned       errors = 0;

    bitmap_first_fit_allocator #(
        .MAP_BITS(MAP_BITS)
    ) uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_entry_index      (i_entry_index),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_allocated_number (o_allocated_number),
        .o_bit_used         (o_bit_used),
        .o_free_left        (o_free_left)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_outcome allocator_outcome(t_op op, logic [IDX_W-1:0] idx);
        t_outcome    r;
        int unsigned stop;
        int unsigned pos;
        bit          found;
        r = '0;
        pos = 0;
        found = 1'b0;
        case (op)
            OP_ALLOC: begin
                stop = (scan_limit > MAP_BITS) ? MAP_BITS : scan_limit;
                for (int unsigned i = scan_first; i < stop; i++) begin
                    if (!found && !map_used[i]) begin
                        found = 1'b1;
                        pos = i;
                    end
                end
                if (found) begin
                    map_used[pos] = 1'b1;
                    if (free_count != '0) begin
                        free_count = free_count - 1'b1;
                    end
                    r.number = NUM_W'(pos + 1);
                end else begin
                    r.status = 1'b1;
                end
            end
            OP_TEST: r.bit_used = map_used[idx];
            OP_MARK: map_used[idx] = 1'b1;
            default: map_used[idx] = 1'b0;
        endcase
        r.free_left = free_count;
        return r;
    endfunction

    function automatic t_stim_row plain_row(t_op op, int unsigned idx);
        t_stim_row r;
        r = '0;
        r.op = op;
        r.idx = IDX_W'(idx);
        return r;
    endfunction

    function automatic t_stim_row typed_row(t_op op, int unsigned idx, int unsigned st,
                                            int unsigned num, int unsigned bu, int unsigned fl);
        t_stim_row r;
        r = plain_row(op, idx);
        r.typed = 1'b1;
        r.outcome.status = st[0];
        r.outcome.number = NUM_W'(num);
        r.outcome.bit_used = bu[0];
        r.outcome.free_left = NUM_W'(fl);
        return r;
    endfunction

    function automatic t_stim_row reg_row(logic [CFGI_W-1:0] ri, int unsigned data);
        t_stim_row r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_index = ri;
        r.reg_data = CFG_W'(data);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    task automatic send_item(input t_stim_row row);
        int unsigned target;
        target = in_count + 1;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= row.op;
        i_entry_index <= row.idx;
        typed_pending <= row.typed;
        typed_outcome <= row.outcome;
        do @(negedge i_clk); while (in_count != target);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFGI_W-1:0] ri, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= ri;
        i_cfg_data <= data;
        case (ri)
            REG_FIRST: scan_first = data[IDX_W-1:0];
            REG_LIMIT: scan_limit = data;
            REG_FREE:  free_count = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                seen.status = o_status;
                seen.number = o_allocated_number;
                seen.bit_used = o_bit_used;
                seen.free_left = o_free_left;
                if (pending_results.size() == 0) begin
                    $display("%0t: result expected none actual %0d/%0d/%0d/%0d", $time,
                             seen.status, seen.number, seen.bit_used, seen.free_left);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, seen.status);
                    check_field("allocated_number", want.number, seen.number);
                    check_field("bit_used", want.bit_used, seen.bit_used);
                    check_field("free_left", want.free_left, seen.free_left);
                end
            end
            if (i_in_valid && o_in_ready) begin
                want = allocator_outcome(i_opcode, i_entry_index);
                if (typed_pending) begin
                    want = typed_outcome;
                end
                pending_results.push_back(want);
                in_count++;
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial begin
        t_op              op;
        logic [IDX_W-1:0] idx;
        int unsigned      hi;
        int unsigned      pick;
        int unsigned      first_v;
        int unsigned      limit_v;
        int unsigned      free_v;

        dir_rows = '{
            typed_row(OP_ALLOC,   0,    0, 1,    0, 1023),
            typed_row(OP_ALLOC,   1023, 0, 2,    0, 1022),
            typed_row(OP_TEST,    0,    0, 0,    1, 1022),
            typed_row(OP_TEST,    1023, 0, 0,    0, 1022),
            typed_row(OP_MARK,    1023, 0, 0,    0, 1022),
            typed_row(OP_TEST,    1023, 0, 0,    1, 1022),
            typed_row(OP_RELEASE, 0,    0, 0,    0, 1022),
            typed_row(OP_ALLOC,   0,    0, 1,    0, 1021),
            typed_row(OP_RELEASE, 1023, 0, 0,    0, 1021),
            typed_row(OP_MARK,    2,    0, 0,    0, 1021),
            typed_row(OP_ALLOC,   512,  0, 4,    0, 1020),
            reg_row(REG_FIRST, 1023),
            reg_row(REG_NONE, 0),
            reg_row(REG_LIMIT, 2047),
            reg_row(REG_FREE, 1),
            typed_row(OP_ALLOC,   0,    0, 1024, 0, 0),
            typed_row(OP_ALLOC,   0,    1, 0,    0, 0),
            plain_row(OP_TEST,    1023),
            reg_row(REG_FIRST, 0),
            reg_row(REG_LIMIT, 3),
            reg_row(REG_FREE, 0),
            typed_row(OP_ALLOC,   0,    1, 0,    0, 0),
            typed_row(OP_RELEASE, 1,    0, 0,    0, 0),
            typed_row(OP_ALLOC,   0,    0, 2,    0, 0),
            reg_row(REG_FIRST, 10),
            reg_row(REG_LIMIT, 10),
            reg_row(REG_FREE, 2047),
            typed_row(OP_ALLOC,   0,    1, 0,    0, 2047),
            plain_row(OP_MARK,    10),
            reg_row(REG_LIMIT, 0),
            reg_row(REG_FIRST, 0),
            typed_row(OP_ALLOC,   0,    1, 0,    0, 2047),
            plain_row(OP_RELEASE, 682),
            plain_row(OP_TEST,    341)
        };

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_reg) begin
                wait_idle();
                write_reg(dir_rows[k].reg_index, dir_rows[k].reg_data);
            end else begin
                send_item(dir_rows[k]);
            end
        end

        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            wait_idle();
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            case (phase)
                0: begin first_v = 0; limit_v = 1024; free_v = 1024; end
                1: begin first_v = 0; limit_v = 40; free_v = $urandom_range(2047); end
                2: begin first_v = 1000; limit_v = 1024; free_v = 0; end
                3: begin first_v = $urandom_range(1023); limit_v = 2047; free_v = 2047; end
                default: begin
                    first_v = $urandom_range(1023);
                    if ($urandom_range(3) == 0) begin
                        limit_v = $urandom_range(2047);
                    end else begin
                        limit_v = first_v + $urandom_range(64);
                    end
                    free_v = $urandom_range(2047);
                end
            endcase
            write_reg(REG_NONE, CFG_W'($urandom_range(2047)));
            write_reg(REG_FIRST, CFG_W'(first_v));
            write_reg(REG_LIMIT, CFG_W'(limit_v));
            write_reg(REG_FREE, CFG_W'(free_v));

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(149) == 0) begin
                    wait_idle();
                end
                pick = $urandom_range(99);
                if (pick < 40) begin
                    op = OP_ALLOC;
                end else if (pick < 60) begin
                    op = OP_TEST;
                end else if (pick < 75) begin
                    op = OP_MARK;
                end else begin
                    op = OP_RELEASE;
                end
                hi = (scan_limit > MAP_BITS) ? MAP_BITS : scan_limit;
                if ($urandom_range(9) < 7 && hi > scan_first) begin
                    idx = IDX_W'($urandom_range(hi - 1, scan_first));
                end else begin
                    idx = IDX_W'($urandom_range(MAP_BITS - 1));
                end
                send_item(plain_row(op, idx));
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
